@@ rtl/core/gcode_line_assembler_macros.svh @@
// assertion macros for the line assembler
`ifndef GCODE_LINE_ASSEMBLER_MACROS_SVH
`define GCODE_LINE_ASSEMBLER_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent holds -> consequent holds in the same cycle
`define GLA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define GLA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GLA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GLA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/gla_pkg.sv @@
`default_nettype none

package gla_pkg;

   localparam int LINE_LENGTH = 64;
   localparam int IDX_W       = $clog2(LINE_LENGTH);
   localparam int LEN_W       = $clog2(LINE_LENGTH + 1);

   localparam logic [7:0] CH_CTRL_X  = 8'h18;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LC_A    = 8'h61;
   localparam logic [7:0] CH_LC_Z    = 8'h7A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_CHAR  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef enum logic [1:0] {
      RT_RESET  = 2'd0,
      RT_STATUS = 2'd1,
      RT_HOLD   = 2'd2,
      RT_START  = 2'd3
   } rt_code_type;

   typedef enum logic [1:0] {
      REG_ALLOW_DOLLAR = 2'd0,
      REG_STRIP_PAREN  = 2'd1,
      REG_STRIP_SEMI   = 2'd2,
      REG_UPPERCASE    = 2'd3
   } reg_index_type;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

endpackage

`default_nettype wire

@@ rtl/core/gcode_line_assembler.sv @@
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_in_byte
// rsp       out        rsp_valid / rsp_stall   rsp_kind, rsp_rt_code, rsp_line_char,
//                                              rsp_line_status, rsp_last
// csr       in/out     apb, pready tied high   4 one-bit registers at 4*i
//
// a byte that emits nothing or one realtime event is taken without leaving idle
// an lf that emits n characters steps through S_READ and S_EMIT once per character:
// a store read, then an output load that waits while the output slot is held
// trim bounds and the '$' test are tracked while the line fills, no scan at lf
// reset is synchronous; the store keeps its contents, only control clears
// rsp_stall holds the output register, and req_stall rises until it frees
`default_nettype none
`include "gcode_line_assembler_macros.svh"

module gcode_line_assembler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_in_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_kind,
   output logic [1:0]                           rsp_rt_code,
   output logic [6:0]                           rsp_line_char,
   output logic                                 rsp_line_status,
   output logic                                 rsp_last,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [gla_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [gla_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [gla_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   localparam int IDX_W = gla_pkg::IDX_W;
   localparam int LEN_W = gla_pkg::LEN_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   // configuration
   logic allow_dollar_ff, strip_paren_ff, strip_semi_ff, uppercase_ff;
   logic csr_write;
   gla_pkg::reg_index_type csr_index;

   // line state
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             paren_ff, paren_in;
   logic             semi_ff, semi_in;
   logic             nb_seen_ff, nb_seen_in;
   logic [IDX_W-1:0] first_nb_ff, first_nb_in;
   logic [LEN_W-1:0] last_nb_ff, last_nb_in;
   logic             dollar_ff, dollar_in;

   // emission sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] end_ff, end_in;
   logic             status_ff, status_in;

   // store
   logic [6:0]       line_mem [gla_pkg::LINE_LENGTH];
   logic [6:0]       rd_data_ff;
   logic             wr_en;
   logic [6:0]       wr_data;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kind_ff, kind_in;
   gla_pkg::rt_code_type code_ff, code_in;
   logic [6:0]           char_ff, char_in;
   logic                 lstat_ff, lstat_in;
   logic                 last_ff, last_in;

   logic       slot_free;
   logic       accept;
   logic [7:0] c;
   logic [7:0] c_up;
   logic       printable;
   logic       blank;
   logic       emit_last;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = gla_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      prdata = '0;
      case (csr_index)
         gla_pkg::REG_ALLOW_DOLLAR: prdata[0] = allow_dollar_ff;
         gla_pkg::REG_STRIP_PAREN:  prdata[0] = strip_paren_ff;
         gla_pkg::REG_STRIP_SEMI:   prdata[0] = strip_semi_ff;
         gla_pkg::REG_UPPERCASE:    prdata[0] = uppercase_ff;
         default:                   prdata    = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_dollar_ff <= 1'b1;
         strip_paren_ff  <= 1'b1;
         strip_semi_ff   <= 1'b1;
         uppercase_ff    <= 1'b1;
      end else if (csr_write && pready) begin
         case (csr_index)
            gla_pkg::REG_ALLOW_DOLLAR: allow_dollar_ff <= pwdata[0];
            gla_pkg::REG_STRIP_PAREN:  strip_paren_ff  <= pwdata[0];
            gla_pkg::REG_STRIP_SEMI:   strip_semi_ff   <= pwdata[0];
            gla_pkg::REG_UPPERCASE:    uppercase_ff    <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign c         = req_in_byte;
   assign printable = ((c >= gla_pkg::PRINT_LO) && (c <= gla_pkg::PRINT_HI))
                      || (c == gla_pkg::CH_TAB);
   assign c_up      = (uppercase_ff && (c >= gla_pkg::CH_LC_A) && (c <= gla_pkg::CH_LC_Z))
                      ? (c - gla_pkg::CASE_SHIFT) : c;
   assign blank     = (c_up == gla_pkg::CH_SPACE) || (c_up == gla_pkg::CH_TAB);
   assign wr_data   = c_up[6:0];
   assign emit_last = ((LEN_W'(idx_ff) + LEN_W'(1)) == end_ff);

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      paren_in     = paren_ff;
      semi_in      = semi_ff;
      nb_seen_in   = nb_seen_ff;
      first_nb_in  = first_nb_ff;
      last_nb_in   = last_nb_ff;
      dollar_in    = dollar_ff;
      state_in     = state_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      code_in      = code_ff;
      char_in      = char_ff;
      lstat_in     = lstat_ff;
      last_in      = last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((c == gla_pkg::CH_CTRL_X) || (c == gla_pkg::CH_QUERY) ||
                   (c == gla_pkg::CH_BANG) || (c == gla_pkg::CH_TILDE)) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = gla_pkg::KIND_EVENT;
                  char_in      = '0;
                  lstat_in     = gla_pkg::STATUS_OK;
                  last_in      = 1'b1;
                  if (c == gla_pkg::CH_CTRL_X) begin
                     code_in    = gla_pkg::RT_RESET;
                     len_in     = '0;
                     ovf_in     = 1'b0;
                     paren_in   = 1'b0;
                     semi_in    = 1'b0;
                     nb_seen_in = 1'b0;
                  end else if (c == gla_pkg::CH_QUERY) begin
                     code_in = gla_pkg::RT_STATUS;
                  end else if (c == gla_pkg::CH_BANG) begin
                     code_in = gla_pkg::RT_HOLD;
                  end else begin
                     code_in = gla_pkg::RT_START;
                  end
               end else if (c == gla_pkg::CH_LF) begin
                  // bounds are latched, so the line state clears right away
                  len_in     = '0;
                  ovf_in     = 1'b0;
                  paren_in   = 1'b0;
                  semi_in    = 1'b0;
                  nb_seen_in = 1'b0;
                  if (ovf_ff) begin
                     state_in  = S_READ;
                     idx_in    = '0;
                     end_in    = LEN_W'(gla_pkg::LINE_LENGTH);
                     status_in = gla_pkg::STATUS_OVERFLOW;
                  end else if (nb_seen_ff && (allow_dollar_ff || !dollar_ff)) begin
                     state_in  = S_READ;
                     idx_in    = first_nb_ff;
                     end_in    = last_nb_ff;
                     status_in = gla_pkg::STATUS_OK;
                  end
               end else if (printable && !semi_ff) begin
                  if (strip_paren_ff && paren_ff) begin
                     if (c == gla_pkg::CH_RPAREN) begin
                        paren_in = 1'b0;
                     end
                  end else if (strip_paren_ff && (c == gla_pkg::CH_LPAREN)) begin
                     paren_in = 1'b1;
                  end else if (strip_semi_ff && (c == gla_pkg::CH_SEMI)) begin
                     semi_in = 1'b1;
                  end else if (len_ff < LEN_W'(gla_pkg::LINE_LENGTH)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                     if (!blank) begin
                        last_nb_in = len_ff + LEN_W'(1);
                        if (!nb_seen_ff) begin
                           nb_seen_in  = 1'b1;
                           first_nb_in = len_ff[IDX_W-1:0];
                           dollar_in   = (c_up == gla_pkg::CH_DOLLAR);
                        end
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = gla_pkg::KIND_CHAR;
               code_in      = gla_pkg::RT_RESET;
               char_in      = rd_data_ff;
               lstat_in     = status_ff;
               last_in      = emit_last;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // store with one write and one read port: write on a stored byte, registered read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[len_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= line_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         paren_ff     <= 1'b0;
         semi_ff      <= 1'b0;
         nb_seen_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         paren_ff     <= paren_in;
         semi_ff      <= semi_in;
         nb_seen_ff   <= nb_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_nb_ff <= first_nb_in;
      last_nb_ff  <= last_nb_in;
      dollar_ff   <= dollar_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      status_ff   <= status_in;
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      char_ff     <= char_in;
      lstat_ff    <= lstat_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_rt_code     = code_ff;
   assign rsp_line_char   = char_ff;
   assign rsp_line_status = lstat_ff;
   assign rsp_last        = last_ff;

   `GLA_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_W'(gla_pkg::LINE_LENGTH))
   `GLA_ASSERT_NOW(a_ovf_full, clock, reset, ovf_ff, len_ff == LEN_W'(gla_pkg::LINE_LENGTH))
   `GLA_ASSERT_NOW(a_emit_range, clock, reset, state_ff != S_IDLE, LEN_W'(idx_ff) < end_ff)
   `GLA_ASSERT_NEXT(a_read_then_emit, clock, reset, state_ff == S_READ, state_ff == S_EMIT)
   `GLA_ASSERT_NOW(a_trim_order, clock, reset, nb_seen_ff, LEN_W'(first_nb_ff) < last_nb_ff)

endmodule

`default_nettype wire
